>>> rtl/cgg_pkg.sv
// shared types and constants of the cosine grain generator and mixer
`timescale 1ns / 1ps
`default_nettype none

package cgg_pkg;

    // longest grain in frames
    localparam logic [23:0] MAX_GRAIN_FRAMES = 24'd1048575;

    typedef logic [2:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t REG_TONE_COEF       = 3'd0;
    localparam cfg_idx_t REG_TONE_START      = 3'd1;
    localparam cfg_idx_t REG_TONE_PREV_START = 3'd2;
    localparam cfg_idx_t REG_ENV_COEF        = 3'd3;
    localparam cfg_idx_t REG_ENV_PREV_START  = 3'd4;
    localparam cfg_idx_t REG_GAIN_LEFT       = 3'd5;
    localparam cfg_idx_t REG_GAIN_RIGHT      = 3'd6;
    localparam cfg_idx_t REG_FRAME_COUNT     = 3'd7;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        OP_SIG,
        OP_TONE,
        OP_LEFT,
        OP_RIGHT,
        OP_ENV
    } mul_op_t;

    typedef struct packed {
        logic    capture;
        logic    mul_en;
        mul_op_t op;
        logic    store_sig;
        logic    store_tone;
        logic    store_left;
        logic    store_right;
        logic    finish;
    } cgg_cmd_t;

    typedef struct packed {
        logic active;
    } cgg_status_t;

endpackage

`default_nettype wire

>>> rtl/cgg_mult.sv
// shared signed 33 x 33 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module cgg_mult (
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/cgg_datapath.sv
// datapath: config registers, oscillators, shared multiplier, mixing and output register
`timescale 1ns / 1ps
`default_nettype none

module cgg_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cgg_pkg::cgg_cmd_t     cmd,
    output cgg_pkg::cgg_status_t  status,
    input  logic                  cfg_wen,
    input  cgg_pkg::cfg_idx_t     cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [47:0]           s_tdata,
    input  logic                  s_tuser,
    output logic [47:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    import cgg_pkg::*;

    localparam logic signed [65:0] RND30 = 66'sh0000_0000_2000_0000;
    localparam logic signed [65:0] RND31 = 66'sh0000_0000_4000_0000;
    localparam logic signed [32:0] ONE_Q30 = 33'sh0_4000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
        logic signed [31:0] r;
        if (x > 37'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -37'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [36:0] x);
        logic signed [23:0] r;
        if (x > 37'sd8388607)
            r = 24'sh7F_FFFF;
        else if (x < -37'sd8388608)
            r = 24'sh80_0000;
        else
            r = x[23:0];
        return r;
    endfunction

    // configuration
    logic signed [31:0] tone_coef_reg, tone_start_reg, tone_prev_start_reg;
    logic signed [31:0] env_coef_reg, env_prev_start_reg;
    logic signed [31:0] gain_left_reg, gain_right_reg;
    logic [19:0]        frame_count_reg;

    // oscillator and grain state
    logic signed [31:0] tone_now_reg, tone_prev_reg, env_now_reg, env_prev_reg;
    logic [19:0]        frames_left_reg;

    // per-frame working registers
    logic signed [23:0] mix_left_reg, mix_right_reg;
    logic signed [31:0] sig_reg, tone_nx_reg;
    logic signed [23:0] res_left_reg, res_right_reg;
    logic signed [23:0] out_left_reg, out_right_reg;
    logic               out_active_reg, out_last_reg;

    logic signed [32:0] mul_a, mul_b, win;
    logic signed [65:0] prod, prod_r30, prod_r31;
    logic signed [35:0] r30;
    logic signed [34:0] r31;
    logic signed [31:0] env_nx;
    logic [23:0]        frames_clip;
    logic               active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_coef_reg       <= 32'sh0;
            tone_start_reg      <= 32'sh4000_0000;
            tone_prev_start_reg <= 32'sh4000_0000;
            env_coef_reg        <= 32'sh0;
            env_prev_start_reg  <= 32'sh4000_0000;
            gain_left_reg       <= 32'sh0;
            gain_right_reg      <= 32'sh0;
            frame_count_reg     <= 20'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_TONE_COEF:       tone_coef_reg       <= cfg_data;
                REG_TONE_START:      tone_start_reg      <= cfg_data;
                REG_TONE_PREV_START: tone_prev_start_reg <= cfg_data;
                REG_ENV_COEF:        env_coef_reg        <= cfg_data;
                REG_ENV_PREV_START:  env_prev_start_reg  <= cfg_data;
                REG_GAIN_LEFT:       gain_left_reg       <= cfg_data;
                REG_GAIN_RIGHT:      gain_right_reg      <= cfg_data;
                REG_FRAME_COUNT:     frame_count_reg     <= cfg_data[19:0];
                default:             ;
            endcase
        end
    end

    assign win = {env_now_reg[31], env_now_reg} - ONE_Q30;

    always_comb
    begin
        unique case (cmd.op)
            OP_SIG:
            begin
                mul_a = {tone_now_reg[31], tone_now_reg};
                mul_b = win;
            end
            OP_TONE:
            begin
                mul_a = {tone_coef_reg[31], tone_coef_reg};
                mul_b = {tone_now_reg[31], tone_now_reg};
            end
            OP_LEFT:
            begin
                mul_a = {sig_reg[31], sig_reg};
                mul_b = {gain_left_reg[31], gain_left_reg};
            end
            OP_RIGHT:
            begin
                mul_a = {sig_reg[31], sig_reg};
                mul_b = {gain_right_reg[31], gain_right_reg};
            end
            OP_ENV:
            begin
                mul_a = {env_coef_reg[31], env_coef_reg};
                mul_b = {env_now_reg[31], env_now_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cgg_mult u_mult (
        .clk (clk),
        .en  (cmd.mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // round half up, then drop the fraction bits
    assign prod_r30 = prod + RND30;
    assign prod_r31 = prod + RND31;
    assign r30      = prod_r30[65:30];
    assign r31      = prod_r31[65:31];

    assign env_nx      = sat32({r30[35], r30} - {{5{env_prev_reg[31]}}, env_prev_reg});
    assign frames_clip = ({4'd0, frame_count_reg} < MAX_GRAIN_FRAMES)
                         ? {4'd0, frame_count_reg} : MAX_GRAIN_FRAMES;
    assign active      = (frames_left_reg != 20'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_now_reg    <= 32'sh0;
            tone_prev_reg   <= 32'sh0;
            env_now_reg     <= 32'sh0;
            env_prev_reg    <= 32'sh0;
            frames_left_reg <= 20'd0;
        end
        else if (cmd.capture && s_tuser)
        begin
            tone_now_reg    <= tone_start_reg;
            tone_prev_reg   <= tone_prev_start_reg;
            env_now_reg     <= 32'sh4000_0000;
            env_prev_reg    <= env_prev_start_reg;
            frames_left_reg <= frames_clip[19:0];
        end
        else if (cmd.finish && active)
        begin
            tone_prev_reg   <= tone_now_reg;
            tone_now_reg    <= tone_nx_reg;
            env_prev_reg    <= env_now_reg;
            env_now_reg     <= env_nx;
            frames_left_reg <= frames_left_reg - 20'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mix_left_reg  <= s_tdata[23:0];
            mix_right_reg <= s_tdata[47:24];
        end
        if (cmd.store_sig)
        begin
            sig_reg <= sat32({r30[35], r30});
        end
        if (cmd.store_tone)
        begin
            tone_nx_reg <= sat32({r30[35], r30} - {{5{tone_prev_reg[31]}}, tone_prev_reg});
        end
        if (cmd.store_left)
        begin
            res_left_reg <= sat24({{2{r31[34]}}, r31}
                                  + {{13{mix_left_reg[23]}}, mix_left_reg});
        end
        if (cmd.store_right)
        begin
            res_right_reg <= sat24({{2{r31[34]}}, r31}
                                   + {{13{mix_right_reg[23]}}, mix_right_reg});
        end
        if (cmd.finish)
        begin
            out_left_reg   <= active ? res_left_reg : mix_left_reg;
            out_right_reg  <= active ? res_right_reg : mix_right_reg;
            out_active_reg <= active;
            out_last_reg   <= (frames_left_reg == 20'd1);
        end
    end

    assign status.active = active;
    assign m_tdata       = {out_right_reg, out_left_reg};
    assign m_tuser       = out_active_reg;
    assign m_tlast       = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/cgg_ctrl.sv
// controller: frame sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none

module cgg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  cgg_pkg::cgg_status_t status,
    output cgg_pkg::cgg_cmd_t    cmd
);

    import cgg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIG,
        ST_TONE,
        ST_LEFT,
        ST_RIGHT,
        ST_ENV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_SIG;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = ST_SIG;
            end
            ST_SIG:
            begin
                // inactive frames skip the arithmetic and pass through
                cmd.mul_en = status.active;
                cmd.op     = OP_SIG;
                state_next = status.active ? ST_TONE : ST_DONE;
            end
            ST_TONE:
            begin
                cmd.mul_en    = 1'b1;
                cmd.op        = OP_TONE;
                cmd.store_sig = 1'b1;
                state_next    = ST_LEFT;
            end
            ST_LEFT:
            begin
                cmd.mul_en     = 1'b1;
                cmd.op         = OP_LEFT;
                cmd.store_tone = 1'b1;
                state_next     = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                cmd.mul_en     = 1'b1;
                cmd.op         = OP_RIGHT;
                cmd.store_left = 1'b1;
                state_next     = ST_ENV;
            end
            ST_ENV:
            begin
                cmd.mul_en      = 1'b1;
                cmd.op          = OP_ENV;
                cmd.store_right = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                // envelope product stays in the multiplier register until the output frees up
                cmd.op     = OP_ENV;
                cmd.finish = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/cosine_grain_generator_mixer_top.sv
// top level of the cosine grain generator and stereo mixer
`timescale 1ns / 1ps
`default_nettype none

// One frame goes in per transfer and one mixed frame comes out per transfer. A frame inside a
// grain runs through the states SIG, TONE, LEFT, RIGHT, ENV and DONE before the next input
// transfer can be taken, a frame outside a grain only through SIG and DONE; a held output
// keeps the frame in DONE while it waits. One shared 33 x 33 multiplier forms, one per cycle,
// the windowed tone, the left and right contributions and the two oscillator steps. The block
// takes a new frame while the previous result still waits in the output register. Configuration
// writes change coefficients and gains at once; start values and the grain length take effect
// at the next restart. There is no clearing pass after reset.

module cosine_grain_generator_mixer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  cgg_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,    // mix_left [23:0], mix_right [47:24]
    input  logic               s_tuser,    // restart
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,    // out_left [23:0], out_right [47:24]
    output logic               m_tuser,    // grain_active
    output logic               m_tlast     // grain_last
);

    import cgg_pkg::*;

    cgg_cmd_t    cmd;
    cgg_status_t status;

    cgg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cgg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/cgg_checker.sv
// port-level checker for the grain generator top, bound to it below
`timescale 1ns / 1ps
`default_nettype none

module cgg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [47:0]        m_tdata,
    input logic               m_tuser,
    input logic               m_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output changed");

    // the final frame of a grain is always an active frame
    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("grain_last without grain_active");

    // one frame at a time: after a transfer the input stays not ready in SIG and in the state after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted while a frame is in work");

    // a result needs at least the sequencing steps before it shows
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

endmodule

bind cosine_grain_generator_mixer_top cgg_checker u_cgg_checker (.*);

`default_nettype wire

>>> verif/tb_cosine_grain_generator_mixer_top.sv
// self-checking testbench of the cosine grain generator and stereo mixer
`timescale 1ns / 1ps

module tb_cosine_grain_generator_mixer_top;
    import cgg_pkg::*;

    localparam int     WATCHDOG_LIMIT   = 5000;
    localparam int     SETTLE_CYCLES    = 12;
    localparam int     PHASES           = 10;
    localparam int     FRAMES_PER_PHASE = 100;
    localparam int     QUIET_PHASE      = 5;
    localparam longint ONE_Q30          = 64'sd1073741824;

    typedef struct packed {
        logic [23:0] out_left;
        logic [23:0] out_right;
        logic        active;
        logic        last;
    } grain_frame_t;

    typedef struct packed {
        logic         is_cfg;
        cfg_idx_t     idx;
        logic [31:0]  data;
        logic         restart;
        logic [23:0]  mix_l;
        logic [23:0]  mix_r;
        logic         typed;
        grain_frame_t exp_frame;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    cfg_idx_t    cfg_index = REG_TONE_COEF;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // mix_left [23:0], mix_right [47:24]
    logic        s_tuser   = 1'b0; // restart
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // out_left [23:0], out_right [47:24]
    logic        m_tuser;          // grain_active
    logic        m_tlast;          // grain_last

    // register copies, reset values
    logic signed [31:0] coef_tone       = 32'sh0000_0000;
    logic signed [31:0] start_tone      = 32'sh4000_0000;
    logic signed [31:0] start_tone_prev = 32'sh4000_0000;
    logic signed [31:0] coef_env        = 32'sh0000_0000;
    logic signed [31:0] start_env_prev  = 32'sh4000_0000;
    logic signed [31:0] gain_l          = 32'sh0000_0000;
    logic signed [31:0] gain_r          = 32'sh0000_0000;
    logic [19:0]        grain_len       = 20'd0;

    // oscillator and grain state
    logic signed [31:0] tone_cur   = '0;
    logic signed [31:0] tone_old   = '0;
    logic signed [31:0] env_cur    = '0;
    logic signed [31:0] env_old    = '0;
    logic [19:0]        frames_rem = '0;

    grain_frame_t mix_expect_q[$];

    int  errors        = 0;
    int  frames_sent   = 0;
    int  restarts_sent = 0;
    int  active_seen   = 0;
    int  settings_used = 0;
    int  stall_cycles  = 0;
    bit  src_idle_en   = 1'b1;
    bit  snk_idle_en   = 1'b1;

    cosine_grain_generator_mixer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // shift right with round half up
    function automatic longint rnd_shr(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fff_ffff;
        else if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [23:0] sat24(input longint x);
        if (x > 64'sd8388607)
            return 24'h7f_ffff;
        else if (x < -64'sd8388608)
            return 24'h80_0000;
        return x[23:0];
    endfunction

    function automatic logic signed [31:0] osc_step(input logic signed [31:0] coef,
                                                    input logic signed [31:0] now,
                                                    input logic signed [31:0] prev);
        return sat32(rnd_shr(longint'(coef) * longint'(now), 30) - longint'(prev));
    endfunction

    function automatic void load_reg(input cfg_idx_t idx, input logic [31:0] v);
        case (idx)
            REG_TONE_COEF:       coef_tone       = v;
            REG_TONE_START:      start_tone      = v;
            REG_TONE_PREV_START: start_tone_prev = v;
            REG_ENV_COEF:        coef_env        = v;
            REG_ENV_PREV_START:  start_env_prev  = v;
            REG_GAIN_LEFT:       gain_l          = v;
            REG_GAIN_RIGHT:      gain_r          = v;
            REG_FRAME_COUNT:     grain_len       = v[19:0];
            default: ;
        endcase
    endfunction

    // expected mixed frame for one accepted input frame; advances the grain state
    function automatic grain_frame_t mix_frame(input logic rs, input logic [23:0] ml,
                                               input logic [23:0] mr);
        grain_frame_t       res;
        longint             win;
        longint             sig;
        longint             cl;
        longint             cr;
        logic signed [31:0] nxt_tone;
        logic signed [31:0] nxt_env;
        res.out_left  = ml;
        res.out_right = mr;
        res.active    = 1'b0;
        res.last      = 1'b0;
        if (rs)
        begin
            tone_cur   = start_tone;
            tone_old   = start_tone_prev;
            env_cur    = 32'sh4000_0000;
            env_old    = start_env_prev;
            frames_rem = (grain_len < MAX_GRAIN_FRAMES) ? grain_len : 20'(MAX_GRAIN_FRAMES);
        end
        if (frames_rem != 20'd0)
        begin
            win           = longint'(env_cur) - ONE_Q30;
            sig           = sat32(rnd_shr(longint'(tone_cur) * win, 30));
            cl            = rnd_shr(sig * longint'(gain_l), 31);
            cr            = rnd_shr(sig * longint'(gain_r), 31);
            res.out_left  = sat24(longint'($signed(ml)) + cl);
            res.out_right = sat24(longint'($signed(mr)) + cr);
            res.active    = 1'b1;
            res.last      = (frames_rem == 20'd1);
            nxt_tone      = osc_step(coef_tone, tone_cur, tone_old);
            tone_old      = tone_cur;
            tone_cur      = nxt_tone;
            nxt_env       = osc_step(coef_env, env_cur, env_old);
            env_old       = env_cur;
            env_cur       = nxt_env;
            frames_rem    = frames_rem - 20'd1;
        end
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic stim_row_t cfg_row(input cfg_idx_t idx, input logic [31:0] v);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = v;
        return row;
    endfunction

    // typed rows expect the mix to pass through unchanged
    function automatic stim_row_t frame_row(input logic rs, input logic [23:0] ml,
                                            input logic [23:0] mr, input logic typed,
                                            input logic act, input logic lst);
        stim_row_t row;
        row                     = '0;
        row.restart             = rs;
        row.mix_l               = ml;
        row.mix_r               = mr;
        row.typed               = typed;
        row.exp_frame.out_left  = ml;
        row.exp_frame.out_right = mr;
        row.exp_frame.active    = act;
        row.exp_frame.last      = lst;
        return row;
    endfunction

    function automatic logic [31:0] pick_reg(input int ph, input cfg_idx_t idx);
        bit real_like;
        real_like = ($urandom_range(2) != 0);
        if (ph == 0)
            return 32'h7fff_ffff + {31'd0, idx == REG_FRAME_COUNT} * 32'h8000_0000;
        if (ph == 1)
            return 32'h8000_0000;
        case (idx)
            REG_TONE_COEF, REG_ENV_COEF:
                return real_like ? 32'h8000_0000 - $urandom_range(1, 32'h0040_0000) : $urandom;
            REG_GAIN_LEFT, REG_GAIN_RIGHT:
                return real_like ? $urandom_range(0, 32'h0200_0000) - 32'h0100_0000 : $urandom;
            REG_FRAME_COUNT:
                return ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40);
            default:
                return real_like ? $urandom_range(0, 32'h8000_0000) - 32'h4000_0000 : $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'h007f_ffff;
            1:       v = 32'h0080_0000;
            2, 3:    v = $urandom;
            default: v = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
        endcase
        return v[23:0];
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        load_reg(idx, v);
    endtask

    // drains the block and lets the oscillator steps of the last frame finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (mix_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_frame(input logic rs, input logic [23:0] ml, input logic [23:0] mr,
                              input logic typed, input grain_frame_t typed_frame);
        grain_frame_t pred;
        if (src_idle_en && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 26)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mr, ml};
        s_tuser  <= rs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = mix_frame(rs, ml, mr);
        mix_expect_q.push_back(typed ? typed_frame : pred);
        frames_sent++;
        if (rs)
            restarts_sent++;
    endtask

    // output side: random back-pressure (none in the quiet phase) and checking of every transfer
    always @(posedge clk)
    begin
        grain_frame_t want;
        if (m_tvalid && m_tready)
        begin
            if (m_tuser)
                active_seen++;
            if (mix_expect_q.size() == 0)
            begin
                $display("%0t: output transfer with nothing expected: expected none, got %h %b %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = mix_expect_q.pop_front();
                check_field("out_left", want.out_left, m_tdata[23:0]);
                check_field("out_right", want.out_right, m_tdata[47:24]);
                check_field("grain_active", {23'd0, want.active}, {23'd0, m_tuser});
                check_field("grain_last", {23'd0, want.last}, {23'd0, m_tlast});
            end
        end
        m_tready <= snk_idle_en ? ($urandom_range(99) >= 26) : 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_cosine_grain_generator_mixer_top NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stim_row_t rows[$];
        int        i;
        int        ph;
        int        r;
        int        k;
        logic      rs;

        // after reset, zero length, extreme registers, restart mid-grain, one-frame grain
        rows.push_back(frame_row(1'b0, 24'h7f_ffff, 24'h80_0000, 1'b1, 1'b0, 1'b0));
        rows.push_back(frame_row(1'b1, 24'h00_0000, 24'hff_ffff, 1'b1, 1'b0, 1'b0));
        rows.push_back(cfg_row(REG_FRAME_COUNT, 32'hfff0_0004));
        rows.push_back(cfg_row(REG_GAIN_LEFT, 32'h7fff_ffff));
        rows.push_back(cfg_row(REG_GAIN_RIGHT, 32'h8000_0000));
        rows.push_back(cfg_row(REG_TONE_COEF, 32'h7fff_ffff));
        rows.push_back(cfg_row(REG_TONE_START, 32'h7fff_ffff));
        rows.push_back(cfg_row(REG_TONE_PREV_START, 32'h8000_0000));
        rows.push_back(cfg_row(REG_ENV_COEF, 32'h8000_0000));
        rows.push_back(cfg_row(REG_ENV_PREV_START, 32'h0000_0000));
        rows.push_back(frame_row(1'b1, 24'h12_3456, 24'hfe_dcba, 1'b1, 1'b1, 1'b0));
        rows.push_back(frame_row(1'b0, 24'h00_0000, 24'h00_0000, 1'b0, 1'b0, 1'b0));
        rows.push_back(frame_row(1'b0, 24'h7f_ffff, 24'h80_0000, 1'b0, 1'b0, 1'b0));
        rows.push_back(frame_row(1'b0, 24'h80_0000, 24'h7f_ffff, 1'b0, 1'b0, 1'b0));
        rows.push_back(frame_row(1'b0, 24'h00_0001, 24'h00_0002, 1'b1, 1'b0, 1'b0));
        rows.push_back(cfg_row(REG_FRAME_COUNT, 32'hffff_ffff));
        rows.push_back(frame_row(1'b1, 24'h55_5555, 24'haa_aaaa, 1'b1, 1'b1, 1'b0));
        rows.push_back(frame_row(1'b0, 24'h0f_0f0f, 24'hf0_f0f0, 1'b0, 1'b0, 1'b0));
        rows.push_back(frame_row(1'b1, 24'haa_aaaa, 24'h55_5555, 1'b1, 1'b1, 1'b0));
        rows.push_back(cfg_row(REG_FRAME_COUNT, 32'h0000_0001));
        rows.push_back(frame_row(1'b1, 24'h7f_ffff, 24'h00_0000, 1'b1, 1'b1, 1'b1));
        rows.push_back(frame_row(1'b0, 24'h80_0000, 24'h00_0001, 1'b1, 1'b0, 1'b0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            if (rows[i].is_cfg)
            begin
                if (i == 0 || !rows[i - 1].is_cfg)
                begin
                    wait_idle();
                    settings_used++;
                end
                write_reg(rows[i].idx, rows[i].data);
                if (i == rows.size() - 1 || !rows[i + 1].is_cfg)
                    cfg_wen <= 1'b0;
            end
            else
                push_frame(rows[i].restart, rows[i].mix_l, rows[i].mix_r, rows[i].typed,
                           rows[i].exp_frame);
        end

        // random phases: all-max and all-min settings first, one phase without idling
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            src_idle_en = (ph != QUIET_PHASE);
            snk_idle_en = (ph != QUIET_PHASE);
            for (r = 0; r < 8; r++)
                write_reg(cfg_idx_t'(r), pick_reg(ph, cfg_idx_t'(r)));
            cfg_wen <= 1'b0;
            settings_used++;
            for (k = 0; k < FRAMES_PER_PHASE; k++)
            begin
                rs = (k == 0) || ($urandom_range(24) == 0);
                push_frame(rs, pick_sample(), pick_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        $display("covered %0d frames, %0d of them restarts, %0d inside a grain",
                 frames_sent, restarts_sent, active_seen);
        $display("over %0d register settings, %0d mismatches", settings_used, errors);
        if (errors == 0 && mix_expect_q.size() == 0)
            $display("tb_cosine_grain_generator_mixer_top OK");
        else
            $display("tb_cosine_grain_generator_mixer_top NOT OK");
        $finish;
    end

endmodule
